>>> hw/rtl/line_raster_pixel_generator_assert.svh
// Assertion macros shared by the line raster modules.
// Every macro expects clk and rst in scope at the point of use.
`ifndef LINE_RASTER_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_RASTER_PIXEL_GENERATOR_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define LRPG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define LRPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lrpg_pkg.sv
`default_nettype none

package lrpg_pkg;

  // Fixed field widths
  localparam int OFFSET_BITS   = 30;
  localparam int CFG_OFS_BITS  = 12;
  localparam int PITCH_BITS    = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [PITCH_BITS-1:0] PITCH_RESET = 16'd16384;

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_OFFSET   = 2'd0,
    CFG_Y_OFFSET   = 2'd1,
    CFG_LINE_PITCH = 2'd2
  } cfg_index_t;

endpackage

`default_nettype wire

>>> hw/rtl/lrpg_stepper.sv
`default_nettype none
`include "line_raster_pixel_generator_assert.svh"

module lrpg_stepper #(
  parameter int COORD_BITS = 12
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  lrpg_pkg::kind_t         in_kind,
  input  wire  [COORD_BITS-1:0]   in_xs,
  input  wire  [COORD_BITS-1:0]   in_ys,
  input  wire  [COORD_BITS-1:0]   in_xe,
  input  wire  [COORD_BITS-1:0]   in_ye,
  output logic                    pix_valid,
  input  wire                     pix_ready,
  output logic [COORD_BITS-1:0]   pix_x,
  output logic [COORD_BITS-1:0]   pix_y,
  output logic                    pix_last
);
  import lrpg_pkg::*;

  localparam int EB = COORD_BITS + 3;

  // Line state
  logic [COORD_BITS-1:0] cur_x, cur_y, major_end, abs_dx, abs_dy;
  logic [EB-1:0]         error_term;
  logic                  x_major, minor_up, active;

  logic [COORD_BITS-1:0] cur_x_next, cur_y_next, major_end_next, abs_dx_next, abs_dy_next;
  logic [EB-1:0]         error_term_next;
  logic                  x_major_next, minor_up_next, active_next, last_next, load;

  logic [COORD_BITS:0]   dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0] ax, ay;
  logic [EB-1:0]         ax_e, ay_e, a_min, a_maj;
  logic                  dx_neg, dy_neg, xm, fwd, take_minor, in_fire;

  // Endpoint distances and axis choice for a start request
  assign dx     = {1'b0, in_xe} - {1'b0, in_xs};
  assign dy     = {1'b0, in_ye} - {1'b0, in_ys};
  assign ndx    = ~dx + 1'b1;
  assign ndy    = ~dy + 1'b1;
  assign dx_neg = dx[COORD_BITS];
  assign dy_neg = dy[COORD_BITS];
  assign ax     = dx_neg ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ay     = dy_neg ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign ax_e   = {{(EB-COORD_BITS){1'b0}}, ax};
  assign ay_e   = {{(EB-COORD_BITS){1'b0}}, ay};
  assign xm     = (ay <= ax);
  assign fwd    = xm ? !dx_neg : !dy_neg;

  // Stored distances seen from the major axis
  assign a_min = {{(EB-COORD_BITS){1'b0}}, (x_major ? abs_dy : abs_dx)};
  assign a_maj = {{(EB-COORD_BITS){1'b0}}, (x_major ? abs_dx : abs_dy)};
  assign take_minor = x_major ? !error_term[EB-1]
                              : (!error_term[EB-1] && (error_term != '0));

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    major_end_next  = major_end;
    abs_dx_next     = abs_dx;
    abs_dy_next     = abs_dy;
    error_term_next = error_term;
    x_major_next    = x_major;
    minor_up_next   = minor_up;
    last_next       = 1'b0;
    load            = 1'b0;
    if (in_kind == KIND_START) begin
      load            = 1'b1;
      abs_dx_next     = ax;
      abs_dy_next     = ay;
      x_major_next    = xm;
      minor_up_next   = (dx_neg && dy_neg) ||
                        (!dx_neg && (ax != '0) && !dy_neg && (ay != '0));
      error_term_next = xm ? ((ay_e << 1) - ax_e) : ((ax_e << 1) - ay_e);
      cur_x_next      = fwd ? in_xs : in_xe;
      cur_y_next      = fwd ? in_ys : in_ye;
      if (xm) begin
        major_end_next = fwd ? in_xe : in_xs;
        last_next      = (cur_x_next == major_end_next);
      end else begin
        major_end_next = fwd ? in_ye : in_ys;
        last_next      = (cur_y_next == major_end_next);
      end
    end else if (active) begin
      load = 1'b1;
      if (take_minor) begin
        error_term_next = error_term + (a_min << 1) - (a_maj << 1);
      end else begin
        error_term_next = error_term + (a_min << 1);
      end
      if (x_major) begin
        cur_x_next = cur_x + 1'b1;
        if (take_minor) begin
          cur_y_next = minor_up ? cur_y + 1'b1 : cur_y - 1'b1;
        end
        last_next = (cur_x_next == major_end);
      end else begin
        cur_y_next = cur_y + 1'b1;
        if (take_minor) begin
          cur_x_next = minor_up ? cur_x + 1'b1 : cur_x - 1'b1;
        end
        last_next = (cur_y_next == major_end);
      end
    end
    active_next = !last_next;
  end

  assign in_ready = !pix_valid || pix_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      major_end  <= '0;
      abs_dx     <= '0;
      abs_dy     <= '0;
      error_term <= '0;
      x_major    <= 1'b0;
      minor_up   <= 1'b0;
      active     <= 1'b0;
      pix_valid  <= 1'b0;
    end else begin
      if (in_fire && load) begin
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        major_end  <= major_end_next;
        abs_dx     <= abs_dx_next;
        abs_dy     <= abs_dy_next;
        error_term <= error_term_next;
        x_major    <= x_major_next;
        minor_up   <= minor_up_next;
        active     <= active_next;
      end
      if (in_ready) begin
        pix_valid <= in_fire && load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && load) begin
      pix_x    <= cur_x_next;
      pix_y    <= cur_y_next;
      pix_last <= last_next;
    end
  end

  `LRPG_ASSERT_NEXT(a_idle_step_silent, in_fire && (in_kind == KIND_STEP) && !active, !pix_valid, "step while idle produced a pixel")
  `LRPG_ASSERT_NEXT(a_last_ends_line, in_fire && load && last_next, !active && pix_last, "line still active after its last pixel")
  `LRPG_ASSERT_ALWAYS(a_xmajor_dist, !(active && x_major) || (abs_dy <= abs_dx), "x-major line with steeper minor distance")
  `LRPG_ASSERT_ALWAYS(a_ymajor_dist, !(active && !x_major) || (abs_dx < abs_dy), "y-major line with shallower major distance")

endmodule

`default_nettype wire

>>> hw/rtl/lrpg_addr.sv
`default_nettype none
`include "line_raster_pixel_generator_assert.svh"

module lrpg_addr #(
  parameter int COORD_BITS      = 12,
  parameter int BYTES_PER_PIXEL = 4
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  pix_valid,
  output logic                                 pix_ready,
  input  wire  [COORD_BITS-1:0]                pix_x,
  input  wire  [COORD_BITS-1:0]                pix_y,
  input  wire                                  pix_last,
  input  wire  [lrpg_pkg::CFG_OFS_BITS-1:0]    x_offset,
  input  wire  [lrpg_pkg::CFG_OFS_BITS-1:0]    y_offset,
  input  wire  [lrpg_pkg::PITCH_BITS-1:0]      line_pitch,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [COORD_BITS-1:0]                out_x,
  output logic [COORD_BITS-1:0]                out_y,
  output logic [lrpg_pkg::OFFSET_BITS-1:0]     out_offset,
  output logic                                 out_last
);
  import lrpg_pkg::*;

  localparam int SUM_BITS = ((COORD_BITS > CFG_OFS_BITS) ? COORD_BITS : CFG_OFS_BITS) + 1;
  localparam int BPP_BITS = 3;

  logic [SUM_BITS-1:0]          x_sum, y_sum;
  logic [SUM_BITS+BPP_BITS-1:0] x_prod;
  logic [SUM_BITS+PITCH_BITS-1:0] y_prod;

  // Product stage
  logic                   s1_valid, s1_ready, s1_last;
  logic [COORD_BITS-1:0]  s1_x, s1_y;
  logic [OFFSET_BITS-1:0] s1_px, s1_py;

  assign x_sum  = SUM_BITS'(pix_x) + SUM_BITS'(x_offset);
  assign y_sum  = SUM_BITS'(pix_y) + SUM_BITS'(y_offset);
  assign x_prod = x_sum * BPP_BITS'(BYTES_PER_PIXEL);
  assign y_prod = y_sum * line_pitch;

  assign s1_ready  = !out_valid || out_ready;
  assign pix_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pix_ready) begin
        s1_valid <= pix_valid;
      end
      if (s1_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      s1_x    <= pix_x;
      s1_y    <= pix_y;
      s1_last <= pix_last;
      s1_px   <= OFFSET_BITS'(x_prod);
      s1_py   <= OFFSET_BITS'(y_prod);
    end
    if (s1_valid && s1_ready) begin
      out_x      <= s1_x;
      out_y      <= s1_y;
      out_last   <= s1_last;
      out_offset <= s1_px + s1_py;
    end
  end

  `LRPG_ASSERT_ALWAYS(a_rose_from_s1, !$rose(out_valid) || $past(s1_valid), "result appeared without a product stage entry")
  `LRPG_ASSERT_NEXT(a_s1_drains, s1_valid && s1_ready, out_valid, "product stage moved but no result held")

endmodule

`default_nettype wire

>>> hw/rtl/line_raster_pixel_generator.sv
// An accepted request's pixel passes the stepper pixel register, the product stage and
// the result register, which drives m_tvalid; low m_tready holds it there.
// Throughput: one request per cycle while m_tready does not stall the pipeline; a start
// or a step each yields at most one pixel. The per-cycle limit is the line state update
// (one add and compare per step). Reset (rst, synchronous, active high) clears the
// pipeline and the line state, and loads x_offset 0, y_offset 0, line_pitch 16384.
`default_nettype none

module line_raster_pixel_generator #(
  parameter int COORD_BITS      = 12,
  parameter int BYTES_PER_PIXEL = 4
) (
  input  wire                                        clk,
  input  wire                                        rst,
  // Request channel
  input  wire                                        s_tvalid,
  output logic                                       s_tready,
  // tdata, low bit up: x_start, y_start, x_end, y_end, zero fill
  input  wire  [((4*COORD_BITS+7)/8)*8-1:0]          s_tdata,
  // tuser: kind (0 start a line, 1 next pixel)
  input  wire                                        s_tuser,
  // Pixel channel
  output logic                                       m_tvalid,
  input  wire                                        m_tready,
  // tdata, low bit up: pixel_x, pixel_y, byte_offset, zero fill
  output logic [((2*COORD_BITS+lrpg_pkg::OFFSET_BITS+7)/8)*8-1:0] m_tdata,
  // tlast: last_pixel
  output logic                                       m_tlast,
  // Configuration writes
  input  wire                                        cfg_we,
  input  wire  [lrpg_pkg::CFG_IDX_BITS-1:0]          cfg_index,
  input  wire  [lrpg_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
  import lrpg_pkg::*;

  localparam int OUT_DATA_BITS = ((2*COORD_BITS+OFFSET_BITS+7)/8)*8;

  // Configuration registers
  logic [CFG_OFS_BITS-1:0] x_offset, y_offset;
  logic [PITCH_BITS-1:0]   line_pitch;

  // Stepper to address unit
  logic                  pix_valid, pix_ready, pix_last;
  logic [COORD_BITS-1:0] pix_x, pix_y;

  // Result register contents
  logic [COORD_BITS-1:0]  out_x, out_y;
  logic [OFFSET_BITS-1:0] out_offset;

  // Hold the panning and pitch; ignore writes to unused indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset   <= '0;
      y_offset   <= '0;
      line_pitch <= PITCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_X_OFFSET:   x_offset   <= cfg_data[CFG_OFS_BITS-1:0];
        CFG_Y_OFFSET:   y_offset   <= cfg_data[CFG_OFS_BITS-1:0];
        CFG_LINE_PITCH: line_pitch <= cfg_data[PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Line walker: takes each request and advances the Bresenham state.
  lrpg_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (kind_t'(s_tuser)),
    .in_xs     (s_tdata[COORD_BITS-1:0]),
    .in_ys     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_xe     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_ye     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_last  (pix_last)
  );

  // Address unit: products, then their sum into the result register.
  lrpg_addr #(
    .COORD_BITS      (COORD_BITS),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_last   (pix_last),
    .x_offset   (x_offset),
    .y_offset   (y_offset),
    .line_pitch (line_pitch),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_offset (out_offset),
    .out_last   (m_tlast)
  );

  // Pack the result, zero fill to whole bytes.
  assign m_tdata = OUT_DATA_BITS'({out_offset, out_y, out_x});

endmodule

`default_nettype wire

>>> test/raster_pixel_check.sv
`timescale 1ns / 1ps

module raster_pixel_check
  import lrpg_pkg::*;
#(
  parameter int COORD_BITS      = 12,
  parameter int BYTES_PER_PIXEL = 4
) (
  input  wire                                            clk,
  input  wire                                            rst,
  input  wire                                            s_tvalid,
  input  wire                                            s_tready,
  // tdata, low bit up: x_start, y_start, x_end, y_end
  input  wire  [((4*COORD_BITS+7)/8)*8-1:0]              s_tdata,
  // tuser: kind
  input  wire                                            s_tuser,
  input  wire                                            m_tvalid,
  input  wire                                            m_tready,
  // tdata, low bit up: pixel_x, pixel_y, byte_offset, zero fill
  input  wire  [((2*COORD_BITS+OFFSET_BITS+7)/8)*8-1:0]  m_tdata,
  // tlast: last_pixel
  input  wire                                            m_tlast,
  input  wire                                            cfg_we,
  input  wire  [CFG_IDX_BITS-1:0]                        cfg_index,
  input  wire  [CFG_DATA_BITS-1:0]                       cfg_data,
  input  wire                                            wrap_up,
  output int                                             fail_count,
  output int                                             pending
);

  localparam int S_W   = ((4*COORD_BITS+7)/8)*8;
  localparam int ERR_W = COORD_BITS + 3;

  typedef struct packed {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [OFFSET_BITS-1:0] offset;
    logic                   last;
  } pixel_t;

  pixel_t expected_pixels[$];
  pixel_t want;
  bit     wrapped;

  // Line state of the predicted rasterizer
  logic [COORD_BITS-1:0]   pos_x, pos_y, run_end, dist_x, dist_y;
  logic signed [ERR_W-1:0] decision;
  logic                    is_x_major, minor_inc, drawing;

  // Register copies
  logic [CFG_OFS_BITS-1:0] pan_x, pan_y;
  logic [PITCH_BITS-1:0]   pitch;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [OFFSET_BITS-1:0] got,
                             logic [OFFSET_BITS-1:0] wanted);
    if (got !== wanted) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, wanted));
    end
  endtask

  function automatic pixel_t pixel_at(logic at_end);
    pixel_t    p;
    logic [63:0] sum;
    sum = (64'(pos_x) + 64'(pan_x)) * 64'(BYTES_PER_PIXEL)
        + (64'(pos_y) + 64'(pan_y)) * 64'(pitch);
    p.x      = pos_x;
    p.y      = pos_y;
    p.offset = sum[OFFSET_BITS-1:0];
    p.last   = at_end;
    return p;
  endfunction

  function automatic logic [COORD_BITS-1:0] minor_step(logic [COORD_BITS-1:0] v);
    return minor_inc ? v + 1'b1 : v - 1'b1;
  endfunction

  // Advance the predicted line by one request and queue the pixel it yields
  task automatic trace_request(kind_t kind, logic [S_W-1:0] data);
    int   xs, ys, xe, ye, dx, dy, ax, ay, e;
    logic at_end;
    if (kind == KIND_START) begin
      xs = int'(data[0*COORD_BITS +: COORD_BITS]);
      ys = int'(data[1*COORD_BITS +: COORD_BITS]);
      xe = int'(data[2*COORD_BITS +: COORD_BITS]);
      ye = int'(data[3*COORD_BITS +: COORD_BITS]);
      dx = xe - xs;
      dy = ye - ys;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      dist_x     = COORD_BITS'(ax);
      dist_y     = COORD_BITS'(ay);
      minor_inc  = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
      is_x_major = ay <= ax;
      if (is_x_major) begin
        decision = ERR_W'(2 * ay - ax);
        if (dx >= 0) begin
          pos_x = COORD_BITS'(xs); pos_y = COORD_BITS'(ys); run_end = COORD_BITS'(xe);
        end else begin
          pos_x = COORD_BITS'(xe); pos_y = COORD_BITS'(ye); run_end = COORD_BITS'(xs);
        end
        at_end = pos_x == run_end;
      end else begin
        decision = ERR_W'(2 * ax - ay);
        if (dy >= 0) begin
          pos_x = COORD_BITS'(xs); pos_y = COORD_BITS'(ys); run_end = COORD_BITS'(ye);
        end else begin
          pos_x = COORD_BITS'(xe); pos_y = COORD_BITS'(ye); run_end = COORD_BITS'(ys);
        end
        at_end = pos_y == run_end;
      end
      drawing = !at_end;
      expected_pixels.push_back(pixel_at(at_end));
    end else if (drawing) begin
      e = int'(decision);
      if (is_x_major) begin
        pos_x = pos_x + 1'b1;
        if (e < 0) begin
          e = e + 2 * int'(dist_y);
        end else begin
          pos_y = minor_step(pos_y);
          e = e + 2 * (int'(dist_y) - int'(dist_x));
        end
        at_end = pos_x == run_end;
      end else begin
        pos_y = pos_y + 1'b1;
        if (e <= 0) begin
          e = e + 2 * int'(dist_x);
        end else begin
          pos_x = minor_step(pos_x);
          e = e + 2 * (int'(dist_x) - int'(dist_y));
        end
        at_end = pos_y == run_end;
      end
      decision = ERR_W'(e);
      drawing  = !at_end;
      expected_pixels.push_back(pixel_at(at_end));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_pixels.delete();
      fail_count = 0;
      pos_x      = '0;
      pos_y      = '0;
      run_end    = '0;
      dist_x     = '0;
      dist_y     = '0;
      decision   = '0;
      is_x_major = 1'b0;
      minor_inc  = 1'b0;
      drawing    = 1'b0;
      pan_x      = '0;
      pan_y      = '0;
      pitch      = PITCH_RESET;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel x=%0d y=%0d with no request waiting",
                                    m_tdata[0 +: COORD_BITS],
                                    m_tdata[COORD_BITS +: COORD_BITS]));
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", OFFSET_BITS'(m_tdata[0 +: COORD_BITS]), OFFSET_BITS'(want.x));
          check_field("pixel_y", OFFSET_BITS'(m_tdata[COORD_BITS +: COORD_BITS]),
                      OFFSET_BITS'(want.y));
          check_field("byte_offset", m_tdata[2*COORD_BITS +: OFFSET_BITS], want.offset);
          check_field("last_pixel", OFFSET_BITS'(m_tlast), OFFSET_BITS'(want.last));
        end
      end
      if (s_tvalid && s_tready) begin
        trace_request(kind_t'(s_tuser), s_tdata);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_OFFSET:   pan_x = cfg_data[CFG_OFS_BITS-1:0];
          CFG_Y_OFFSET:   pan_y = cfg_data[CFG_OFS_BITS-1:0];
          CFG_LINE_PITCH: pitch = cfg_data[PITCH_BITS-1:0];
          default: ;
        endcase
      end
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (expected_pixels.size() != 0) begin
          report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import lrpg_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int S_W          = ((4*COORD_BITS+7)/8)*8;
  localparam int M_W          = ((2*COORD_BITS+OFFSET_BITS+7)/8)*8;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  // Margin for the pipeline registers to empty before a register write
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 112;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 100000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  wire                      s_tready;
  logic [S_W-1:0]           s_tdata;
  logic                     s_tuser;
  wire                      m_tvalid;
  logic                     m_tready;
  wire  [M_W-1:0]           m_tdata;
  wire                      m_tlast;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     wrap_up;
  int                       fail_count;
  int                       pending;

  // Shared by both sides: percentage of cycles spent idle
  int gap_pct = 20;
  // Long receiver hold-offs: requested by the stimulus, served by the receiver
  int stall_requests = 0;
  int stall_served   = 0;
  int cycle_count    = 0;

  always #2 clk = ~clk;

  line_raster_pixel_generator #(
    .COORD_BITS      (COORD_BITS),
    .BYTES_PER_PIXEL (4)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  raster_pixel_check #(
    .COORD_BITS      (COORD_BITS),
    .BYTES_PER_PIXEL (4)
  ) pixel_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wrap_up    (wrap_up),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Bound the run; a hang ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_raster_pixel_generator test failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_served < stall_requests) begin
        stall_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = $urandom_range(99) >= gap_pct;
      end
    end
  end

  function automatic logic [S_W-1:0] random_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[S_W-1:0];
  endfunction

  function automatic logic [S_W-1:0] endpoints(int xs, int ys, int xe, int ye);
    return S_W'({COORD_BITS'(ye), COORD_BITS'(xe), COORD_BITS'(ys), COORD_BITS'(xs)});
  endfunction

  // Favour the edges of the coordinate range now and then
  function automatic int pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return COORD_MAX;
    return $urandom_range(COORD_MAX);
  endfunction

  // Offer one request, idling at random first; entered and left at a falling edge
  task automatic send_request(kind_t kind, logic [S_W-1:0] data);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Step requests carry random data, which the block ignores
  task automatic step_n(int n);
    repeat (n) send_request(KIND_STEP, random_word());
  endtask

  // Drop valid, drain every pixel, then let the pipe empty of idle steps
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(int xo, int yo, int pitch);
    cfg_we    = 1'b1;
    cfg_index = CFG_X_OFFSET;
    cfg_data  = CFG_DATA_BITS'(xo);
    @(negedge clk);
    cfg_index = CFG_Y_OFFSET;
    cfg_data  = CFG_DATA_BITS'(yo);
    @(negedge clk);
    cfg_index = CFG_LINE_PITCH;
    cfg_data  = CFG_DATA_BITS'(pitch);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    int  phase, sent, xs, ys, xe, ye, dx, dy, reach, steps, r;
    bit  paused;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = KIND_START;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_X_OFFSET;
    cfg_data  = '0;
    wrap_up   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset register values
    // Single-point line at the origin, then a step with no line active
    send_request(KIND_START, endpoints(0, 0, 0, 0));
    step_n(1);
    // Single-point line at the far corner
    send_request(KIND_START, endpoints(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // Full-range diagonal, swapped, cut off by the next start
    send_request(KIND_START, endpoints(COORD_MAX, 0, 0, COORD_MAX));
    step_n(2);
    // Y-major, swapped, minor coordinate falling; one surplus step
    send_request(KIND_START, endpoints(10, 20, 11, 16));
    step_n(5);
    // Horizontal and vertical lines: no minor distance
    send_request(KIND_START, endpoints(100, 50, 95, 50));
    step_n(5);
    send_request(KIND_START, endpoints(7, 3, 7, 0));
    step_n(3);
    // X-major rising line with error ties
    send_request(KIND_START, endpoints(0, 0, 4, 2));
    step_n(4);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       apply_setting(COORD_MAX, COORD_MAX, 65535);
        1:       apply_setting(0, 0, 0);
        3:       apply_setting(COORD_MAX, 0, 4);
        4:       apply_setting(0, COORD_MAX, 1);
        default: apply_setting($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                               $urandom_range(65535));
      endcase
      // Phase 3 runs with no idling on either side
      gap_pct = (phase == 3) ? 0 : 20;
      // Phase 2 opens with a long receiver hold-off while requests keep coming
      if (phase == 2) stall_requests++;

      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        // Halfway through, hold the sender until every pixel has come back
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          paused   = 1'b1;
          s_tvalid = 1'b0;
          while (pending != 0) @(negedge clk);
          @(negedge clk);
        end
        if ($urandom_range(99) < 85) begin
          // Well-formed line: a start, then steps up to its far end
          reach = ($urandom_range(99) < 5) ? 120 : 16;
          xs = pick_coord();
          ys = pick_coord();
          dx = $urandom_range(reach);
          dy = $urandom_range(reach);
          if ($urandom_range(1)) dx = -dx;
          if ($urandom_range(1)) dy = -dy;
          xe = xs + dx;
          ye = ys + dy;
          if (xe < 0 || xe > COORD_MAX) xe = xs - dx;
          if (ye < 0 || ye > COORD_MAX) ye = ys - dy;
          steps = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
                  (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
          r = $urandom_range(99);
          // Cut some lines short, overrun the end of others
          if (r < 10 && steps > 0) steps = $urandom_range(steps - 1);
          else if (r < 20) steps += $urandom_range(3, 1);
          send_request(KIND_START, endpoints(xs, ys, xe, ye));
          step_n(steps);
          sent += steps + 1;
        end else begin
          // Noise: a short burst of requests of any kind with any data
          repeat ($urandom_range(3, 1)) begin
            send_request(kind_t'($urandom_range(1)), random_word());
            sent++;
          end
        end
      end
    end

    settle();
    gap_pct = 20;
    wrap_up = 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("line_raster_pixel_generator test passed");
    end else begin
      $display("line_raster_pixel_generator test failed");
    end
    $finish;
  end

endmodule
